/* src/swnr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swnr_pkg
// Shared constants, types and codes of the sliding window negative rank filter.
// ----------------------------------------------------------------------------
package swnr_pkg;

  // sizing
  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int SLOT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W      = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W       = ($clog2(MAX_WINDOW) > CFG_W) ? $clog2(MAX_WINDOW) : CFG_W;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

  // rank select tree
  localparam int GROUP       = 16;
  localparam int NGROUPS     = (MAX_WINDOW + GROUP - 1) / GROUP;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK        = 2'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic    clr;
    logic    del;
    logic    ins;
    sample_t key;
  } swnr_ctl_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEL  = 5'b00010,
    S_INS  = 5'b00100,
    S_TREE = 5'b01000,
    S_OUT  = 5'b10000
  } swnr_state_t;

endpackage

/* src/swnr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swnr_cell
// One slot of the sorted sample row: deletes by shifting from the right and
// inserts by shifting from the left, talking only to its two neighbors.
// ----------------------------------------------------------------------------
module swnr_cell (
  input  logic                clk,
  input  logic                rst,
  input  swnr_pkg::swnr_ctl_t ctl,
  input  swnr_pkg::sample_t   left_val,
  input  logic                left_vld,
  input  logic                left_ge,
  input  swnr_pkg::sample_t   right_val,
  input  logic                right_vld,
  output swnr_pkg::sample_t   val,
  output logic                vld,
  output logic                ge
);

  swnr_pkg::sample_t val_next;
  logic              vld_next;
  logic              shift_del;

  // position tests against the broadcast key
  always_comb begin
    shift_del = vld && (val >= ctl.key);
    ge        = !vld || (val > ctl.key);
  end

  // next cell contents
  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctl.clr) begin
      vld_next = 1'b0;
    end else if (ctl.del && shift_del) begin
      val_next = right_val;
      vld_next = right_vld;
    end else if (ctl.ins && ge) begin
      if (left_ge) begin
        val_next = left_val;
        vld_next = left_vld;
      end else begin
        val_next = ctl.key;
        vld_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

/* src/swnr_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swnr_select
// Picks the cell at the rank position when it holds a negative sample,
// through a registered two-level or-tree.
// ----------------------------------------------------------------------------
module swnr_select (
  input  logic                            clk,
  input  swnr_pkg::sample_t               cell_val [swnr_pkg::MAX_WINDOW],
  input  logic [swnr_pkg::MAX_WINDOW-1:0] cell_vld,
  input  logic [swnr_pkg::IDX_W-1:0]      rank_idx,
  output swnr_pkg::sample_t               pick
);

  logic [swnr_pkg::SAMPLE_BITS-1:0] grp_or      [swnr_pkg::NGROUPS];
  logic [swnr_pkg::SAMPLE_BITS-1:0] grp_or_next [swnr_pkg::NGROUPS];
  logic [swnr_pkg::SAMPLE_BITS-1:0] final_or;

  // first level: each group passes the matching negative cell, if any
  always_comb begin
    for (int g = 0; g < swnr_pkg::NGROUPS; g++) begin
      grp_or_next[g] = '0;
      for (int k = 0; k < swnr_pkg::GROUP; k++) begin
        if (g * swnr_pkg::GROUP + k < swnr_pkg::MAX_WINDOW) begin
          if (cell_vld[g * swnr_pkg::GROUP + k]
              && cell_val[g * swnr_pkg::GROUP + k][swnr_pkg::SAMPLE_BITS-1]
              && (rank_idx == swnr_pkg::IDX_W'(g * swnr_pkg::GROUP + k))) begin
            grp_or_next[g] = grp_or_next[g] | cell_val[g * swnr_pkg::GROUP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_or <= grp_or_next;
  end

  // second level over the group results
  always_comb begin
    final_or = '0;
    for (int g = 0; g < swnr_pkg::NGROUPS; g++) begin
      final_or = final_or | grp_or[g];
    end
  end

  assign pick = swnr_pkg::sample_t'(final_or);

endmodule

/* src/sliding_window_negative_rank_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_negative_rank_filter
// Reports the rank-th smallest negative sample of a sliding window.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one item at a time; the last window_size
// samples are kept sorted in a row of MAX_WINDOW cells, and a circular store
// remembers arrival order so the oldest sample can be evicted. Once the
// window is full every item yields one beauty item on the m_ stream: the
// rank-th smallest negative sample, or 0 when there are fewer negatives.
// While the window fills an item passes through accept and insert and gives
// no result; the item that fills the window also goes through the rank
// select, and every later item adds a delete step: the accept cycle reads
// the evicted sample from the store, the delete state removes it from the
// cell row, the insert state inserts the new sample, and the tree and output
// states go through the registered rank select into the output register.
// The next item is taken once the result sits in the output register; a
// result that is still unread holds the next one in the last select cycle,
// which stalls the input.
// new_sequence or a write of window_size empties the window at once; there
// is no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_negative_rank_filter (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swnr_pkg::DATA_W-1:0]       s_tdata,   // sample
  input  logic                              s_tuser,   // new_sequence
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swnr_pkg::DATA_W-1:0]       m_tdata,   // beauty
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swnr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swnr_pkg::CFG_W-1:0]        cfg_data
);

  swnr_pkg::swnr_state_t state;
  swnr_pkg::swnr_state_t state_next;

  logic [swnr_pkg::CFG_W-1:0]  window_size;
  logic [swnr_pkg::CFG_W-1:0]  rank;
  logic [swnr_pkg::FILL_W-1:0] fill_level;
  logic [swnr_pkg::SLOT_W-1:0] write_slot;
  swnr_pkg::sample_t           sample_q;
  logic                        evict;
  logic                        emit;
  swnr_pkg::sample_t           evicted;

  swnr_pkg::sample_t           window_store [swnr_pkg::MAX_WINDOW];

  logic                        in_acc;
  logic                        cfg_acc;
  logic                        clr;
  swnr_pkg::sample_t           in_sample;
  logic [swnr_pkg::FILL_W-1:0] span_w;
  logic [swnr_pkg::FILL_W-1:0] fill_eff;
  logic [swnr_pkg::SLOT_W-1:0] slot_eff;
  logic [swnr_pkg::FILL_W:0]   old_sum;
  logic [swnr_pkg::SLOT_W-1:0] old_addr;
  logic                        full;
  logic [swnr_pkg::FILL_W-1:0] fill_next;
  logic [swnr_pkg::SLOT_W-1:0] slot_next;
  logic [swnr_pkg::CFG_W-1:0]  rank_eff;
  logic [swnr_pkg::IDX_W-1:0]  rank_idx;

  swnr_pkg::swnr_ctl_t                ctl;
  swnr_pkg::sample_t                  cell_val [swnr_pkg::MAX_WINDOW];
  logic [swnr_pkg::MAX_WINDOW-1:0]    cell_vld;
  logic [swnr_pkg::MAX_WINDOW-1:0]    cell_ge;
  swnr_pkg::sample_t                  pick;
  logic [swnr_pkg::SAMPLE_BITS-1:0]   pick_bits;

  // handshakes
  assign s_tready  = (state == swnr_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_sample = swnr_pkg::sample_t'(s_tdata[swnr_pkg::SAMPLE_BITS-1:0]);
  assign clr       = (in_acc && s_tuser)
                     || (cfg_acc && (cfg_index == swnr_pkg::REG_WINDOW_SIZE));

  // effective window span and rank
  always_comb begin
    if (window_size == '0) begin
      span_w = swnr_pkg::FILL_W'(1);
    end else if (int'(window_size) > swnr_pkg::MAX_WINDOW) begin
      span_w = swnr_pkg::FILL_W'(swnr_pkg::MAX_WINDOW);
    end else begin
      span_w = swnr_pkg::FILL_W'(window_size);
    end
    rank_eff = (rank == '0) ? swnr_pkg::CFG_W'(1) : rank;
    rank_idx = swnr_pkg::IDX_W'(rank_eff) - swnr_pkg::IDX_W'(1);
  end

  // window bookkeeping at accept
  always_comb begin
    fill_eff = s_tuser ? '0 : fill_level;
    slot_eff = s_tuser ? '0 : write_slot;
    full     = (fill_eff >= span_w);
    old_sum  = (swnr_pkg::FILL_W+1)'(slot_eff)
               + (swnr_pkg::FILL_W+1)'(swnr_pkg::MAX_WINDOW)
               - (swnr_pkg::FILL_W+1)'(span_w);
    if (old_sum >= (swnr_pkg::FILL_W+1)'(swnr_pkg::MAX_WINDOW)) begin
      old_sum = old_sum - (swnr_pkg::FILL_W+1)'(swnr_pkg::MAX_WINDOW);
    end
    old_addr  = old_sum[swnr_pkg::SLOT_W-1:0];
    fill_next = full ? fill_eff : fill_eff + swnr_pkg::FILL_W'(1);
    slot_next = (slot_eff == swnr_pkg::SLOT_W'(swnr_pkg::MAX_WINDOW - 1))
                ? '0 : slot_eff + swnr_pkg::SLOT_W'(1);
  end

  // arrival-order store: evicted sample read before the slot is rewritten
  always_ff @(posedge clk) begin
    if (in_acc) begin
      evicted                <= window_store[old_addr];
      window_store[slot_eff] <= in_sample;
    end
  end

  // configuration registers and window counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swnr_pkg::CFG_W'(1);
      rank        <= swnr_pkg::CFG_W'(1);
      fill_level  <= '0;
      write_slot  <= '0;
    end else begin
      if (cfg_acc && (cfg_index == swnr_pkg::REG_WINDOW_SIZE)) begin
        window_size <= cfg_data;
      end else if (cfg_acc && (cfg_index == swnr_pkg::REG_RANK)) begin
        rank <= cfg_data;
      end
      if (cfg_acc && (cfg_index == swnr_pkg::REG_WINDOW_SIZE)) begin
        fill_level <= '0;
        write_slot <= '0;
      end else if (in_acc) begin
        fill_level <= fill_next;
        write_slot <= slot_next;
      end
    end
  end

  // item payload captured at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_q <= in_sample;
      evict    <= full;
      emit     <= (fill_next >= span_w);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      swnr_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = full ? swnr_pkg::S_DEL : swnr_pkg::S_INS;
        end
      end
      swnr_pkg::S_DEL: begin
        state_next = swnr_pkg::S_INS;
      end
      swnr_pkg::S_INS: begin
        state_next = emit ? swnr_pkg::S_TREE : swnr_pkg::S_IDLE;
      end
      swnr_pkg::S_TREE: begin
        state_next = swnr_pkg::S_OUT;
      end
      swnr_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = swnr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swnr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swnr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command to the cell row
  always_comb begin
    ctl.clr = clr;
    ctl.del = (state == swnr_pkg::S_DEL) && evict;
    ctl.ins = (state == swnr_pkg::S_INS);
    ctl.key = (state == swnr_pkg::S_DEL) ? evicted : sample_q;
  end

  // sorted cell row
  for (genvar i = 0; i < swnr_pkg::MAX_WINDOW; i++) begin : g_cell
    swnr_pkg::sample_t lv;
    logic              lvld;
    logic              lge;
    swnr_pkg::sample_t rv;
    logic              rvld;

    if (i == 0) begin : g_first
      assign lv   = ctl.key;
      assign lvld = 1'b0;
      assign lge  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_val[i-1];
      assign lvld = cell_vld[i-1];
      assign lge  = cell_ge[i-1];
    end

    if (i == swnr_pkg::MAX_WINDOW - 1) begin : g_last
      assign rv   = ctl.key;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rv   = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end

    swnr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left_val  (lv),
      .left_vld  (lvld),
      .left_ge   (lge),
      .right_val (rv),
      .right_vld (rvld),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .ge        (cell_ge[i])
    );
  end

  // rank select
  swnr_select u_select (
    .clk      (clk),
    .cell_val (cell_val),
    .cell_vld (cell_vld),
    .rank_idx (rank_idx),
    .pick     (pick)
  );

  assign pick_bits = pick;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == swnr_pkg::S_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == swnr_pkg::S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= swnr_pkg::DATA_W'(pick_bits);
    end
  end

  // occupied cells match the fill level between items
  assert property (@(posedge clk) disable iff (rst)
    (state == swnr_pkg::S_IDLE) |-> ($countones(cell_vld) == int'(fill_level)))
    else $error("cell occupancy differs from fill level");

  // window never holds more than its span
  assert property (@(posedge clk) disable iff (rst)
    (state == swnr_pkg::S_IDLE) |-> (fill_level <= span_w))
    else $error("fill level above window span");

  // a result appears only from the output state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == swnr_pkg::S_OUT))
    else $error("result raised outside output state");

endmodule

/* dv/sliding_window_negative_rank_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_negative_rank_filter_test
// Self-checking bench for the sliding window negative rank filter.
// ----------------------------------------------------------------------------
// Signed samples are streamed in through a queue-fed driver. A monitor keeps
// its own copy of the window, the per-value negative counts and the register
// settings, predicts the beauty item that each accepted sample produces and
// checks every output item in order. Register writes happen only with the
// block drained; phases cover tiny, mid-size and saturated windows, ranks of
// zero, in-range and out-of-range, restarts, random idling on both sides and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sliding_window_negative_rank_filter_test;

  localparam int SAMPLE_BITS  = swnr_pkg::SAMPLE_BITS;
  localparam int MAX_WINDOW   = swnr_pkg::MAX_WINDOW;
  localparam int CFG_IDX_W    = swnr_pkg::CFG_IDX_W;
  localparam int CFG_W        = swnr_pkg::CFG_W;
  localparam int DATA_W       = swnr_pkg::DATA_W;
  localparam int NEG_LEVELS   = 1 << (SAMPLE_BITS - 1);
  localparam int CLUSTER_BASE = -50;
  localparam int TARGET_ITEMS = 1850;
  localparam int CALM_ITEMS   = 100;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = swnr_pkg::REG_WINDOW_SIZE;
  localparam logic [CFG_IDX_W-1:0] REG_RANK        = swnr_pkg::REG_RANK;

  // register indexes the block does not implement
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef swnr_pkg::sample_t sample_t;

  typedef struct {
    sample_t sample;
    logic    restart;
  } sample_item_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DATA_W-1:0]    m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // pending samples and predicted beauty items
  sample_item_t sample_q[$];
  sample_t      beauty_q[$];

  // predictor state
  sample_t      window_mem[MAX_WINDOW];
  int unsigned  neg_count[NEG_LEVELS];
  int unsigned  fill_level;
  int unsigned  write_slot;
  logic [CFG_W-1:0] win_reg;
  logic [CFG_W-1:0] rank_reg;

  // bookkeeping
  logic        in_fire      = 1'b0;
  int unsigned idle_pct     = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned cfg_writes   = 0;
  int unsigned restarts     = 0;
  int unsigned cycle_count  = 0;

  sliding_window_negative_rank_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // sample
    .s_tuser   (s_tuser),    // new_sequence
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // beauty
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // empty the predicted window and counts
  task automatic clear_window();
    foreach (neg_count[i]) neg_count[i] = 0;
    fill_level = 0;
    write_slot = 0;
  endtask

  // add or remove one sample from the negative counts
  task automatic count_sample(input sample_t smp, input logic add);
    int idx;
    if (smp < 0) begin
      idx = int'(smp) + NEG_LEVELS;
      if (add) begin
        neg_count[idx]++;
      end else if (neg_count[idx] > 0) begin
        neg_count[idx]--;
      end
    end
  endtask

  // advance the predicted window by one sample, report the beauty if full
  task automatic filter_step(input sample_t smp, input logic restart,
                             output logic emits, output sample_t beauty);
    int unsigned span_now;
    int unsigned old_slot;
    int unsigned want;
    int unsigned seen;
    logic        found;
    span_now = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
    if (restart) clear_window();
    if (fill_level >= span_now) begin
      old_slot = (write_slot + MAX_WINDOW - span_now) % MAX_WINDOW;
      count_sample(window_mem[old_slot], 1'b0);
    end else begin
      fill_level++;
    end
    window_mem[write_slot] = smp;
    count_sample(smp, 1'b1);
    write_slot = (write_slot + 1) % MAX_WINDOW;
    emits  = (fill_level >= span_now);
    beauty = '0;
    if (emits) begin
      want  = (rank_reg == 0) ? 1 : rank_reg;
      seen  = 0;
      found = 1'b0;
      for (int i = 0; i < NEG_LEVELS; i++) begin
        seen += neg_count[i];
        if (!found && seen >= want) begin
          found  = 1'b1;
          beauty = sample_t'(i - NEG_LEVELS);
        end
      end
    end
  endtask

  // random sample: negatives, extremes and a cluster that repeats values
  function automatic sample_t random_sample(int unsigned neg_pct);
    logic [SAMPLE_BITS-2:0] low;
    sample_t                smp;
    low = (SAMPLE_BITS-1)'($urandom());
    if ($urandom_range(0, 99) < neg_pct) begin
      case ($urandom_range(0, 7)) inside
        0:       smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        1:       smp = '1;
        [2:3]:   smp = sample_t'(CLUSTER_BASE + int'($urandom_range(0, 4)));
        default: smp = {1'b1, low};
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       smp = '0;
        1:       smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        default: smp = {1'b0, low};
      endcase
    end
    return smp;
  endfunction

  task automatic push_sample(input int smp, input logic restart);
    sample_item_t it;
    it.sample  = sample_t'(smp);
    it.restart = restart;
    if (restart) restarts++;
    sample_q = {sample_q, it};
  endtask

  task automatic queue_random(int unsigned n, int unsigned neg_pct, int unsigned restart_pct);
    for (int unsigned i = 0; i < n; i++) begin
      push_sample(int'(random_sample(neg_pct)), $urandom_range(0, 99) < restart_pct);
    end
  endtask

  // wait until every sample is taken and every beauty item has arrived
  task automatic settle();
    while (sample_q.size() != 0 || s_tvalid || beauty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sample driver with random gaps between items
  always @(negedge clk) begin : drive_samples
    sample_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 2);
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        it = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'($unsigned(it.sample));
        s_tuser  <= it.restart;
        samples_sent++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output ready: one long hold-off, then random stall bursts
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && sample_q.size() > 30 && results_seen > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check beauty items, track register writes, predict samples
  always @(posedge clk) begin : watch
    sample_t got;
    sample_t want_b;
    sample_t beauty;
    logic    emits;
    in_fire = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = sample_t'(m_tdata[SAMPLE_BITS-1:0]);
        if (beauty_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beauty item: expected none, actual %0d", $time, got);
        end else begin
          want_b = beauty_q.pop_front();
          if (m_tdata !== DATA_W'($unsigned(want_b))) begin
            errors++;
            $display("%0t: beauty mismatch: expected %0d, actual %0d", $time, want_b, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == REG_WINDOW_SIZE) begin
          win_reg = cfg_data;
          clear_window();
        end else if (cfg_index == REG_RANK) begin
          rank_reg = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        in_fire = 1'b1;
        filter_step(sample_t'(s_tdata[SAMPLE_BITS-1:0]), s_tuser, emits, beauty);
        if (emits) beauty_q = {beauty_q, beauty};
      end
    end
  end

  // run length guard
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_negative_rank_filter_test: FAIL");
      $finish;
    end
  end

  // stimulus phases
  initial begin : stimulus
    int unsigned p;
    int unsigned planned;
    int unsigned win;
    int unsigned rnk;
    int unsigned n;
    int unsigned neg_pct;
    int unsigned restart_pct;
    win_reg  = 1;
    rank_reg = 1;
    foreach (window_mem[i]) window_mem[i] = '0;
    clear_window();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: window of four, second smallest negative
    write_reg(REG_WINDOW_SIZE, 9'd4);
    write_reg(REG_RANK, 9'd2);
    push_sample(-128, 1'b0);
    push_sample(127, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(-128, 1'b0);
    push_sample(-128, 1'b0);
    push_sample(1, 1'b0);
    push_sample(2, 1'b0);
    push_sample(-50, 1'b1);
    push_sample(-51, 1'b0);
    push_sample(-49, 1'b0);
    push_sample(-50, 1'b0);
    push_sample(-7, 1'b0);
    push_sample(100, 1'b0);
    settle();

    // rank zero acts as rank one, window kept across a rank write
    write_reg(REG_RANK, 9'd0);
    push_sample(-3, 1'b0);
    push_sample(5, 1'b0);
    settle();

    // window zero acts as a single sample window
    write_reg(REG_WINDOW_SIZE, 9'd0);
    push_sample(-9, 1'b0);
    push_sample(4, 1'b0);
    push_sample(-128, 1'b0);
    settle();

    // rank beyond the window always gives zero; spare indexes do nothing
    write_reg(REG_WINDOW_SIZE, 9'd3);
    write_reg(REG_RANK, 9'd5);
    write_reg(REG_SPARE_2, CFG_W'($urandom()));
    write_reg(REG_SPARE_3, 9'h1FF);
    push_sample(-1, 1'b0);
    push_sample(-2, 1'b0);
    push_sample(-3, 1'b0);
    push_sample(-4, 1'b0);
    settle();
    planned = 23;

    // random phases
    p = 0;
    while (planned < TARGET_ITEMS - CALM_ITEMS) begin
      neg_pct     = $urandom_range(20, 95);
      restart_pct = ($urandom_range(0, 5) == 0) ? 25 : 2;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 35;
      endcase
      n = $urandom_range(40, 120);
      if (p == 0) begin
        // small window, long enough phase for the output hold-off
        write_reg(REG_WINDOW_SIZE, 9'd4);
        write_reg(REG_RANK, 9'd1);
        n           = 120;
        neg_pct     = 60;
        restart_pct = 0;
        idle_pct    = 10;
      end else if (p == 2) begin
        write_reg(REG_WINDOW_SIZE, 9'(MAX_WINDOW));
        write_reg(REG_RANK, 9'd1);
        n           = 320;
        restart_pct = 0;
      end else if (p == 6) begin
        // size above the maximum saturates
        write_reg(REG_WINDOW_SIZE, 9'h1FF);
        write_reg(REG_RANK, 9'(200 + $urandom_range(0, 56)));
        n           = 320;
        neg_pct     = 95;
        restart_pct = 0;
      end else begin
        case ($urandom_range(0, 5))
          0: begin
            write_reg(REG_WINDOW_SIZE, CFG_W'($urandom_range(0, 1)));
            write_reg(REG_RANK, CFG_W'($urandom_range(0, 2)));
          end
          1: begin
            // rank only, window contents carry over
            rnk = ($urandom_range(0, 3) == 0) ? 9'h1FF : $urandom_range(0, 12);
            write_reg(REG_RANK, CFG_W'(rnk));
          end
          2: begin
            write_reg(REG_SPARE_2, CFG_W'($urandom()));
            write_reg(REG_SPARE_3, CFG_W'($urandom()));
          end
          default: begin
            win = $urandom_range(2, 20);
            rnk = $urandom_range(0, win + 3);
            write_reg(REG_WINDOW_SIZE, CFG_W'(win));
            write_reg(REG_RANK, CFG_W'(rnk));
          end
        endcase
      end
      queue_random(n, neg_pct, restart_pct);
      planned += n;
      settle();
      p++;
    end

    // final stretch with no idling
    idle_pct = 0;
    write_reg(REG_WINDOW_SIZE, 9'd6);
    write_reg(REG_RANK, 9'd2);
    queue_random(CALM_ITEMS, 70, 3);
    settle();

    $display("covered %0d samples, %0d beauty items, %0d register writes, %0d phases",
             samples_sent, results_seen, cfg_writes, p + 5);
    $display("windows from 0 to 511 requested, %0d restarts, output hold-off %0s",
             restarts, hold_done ? "done" : "missed");
    if (errors == 0) begin
      $display("sliding_window_negative_rank_filter_test: PASS");
    end else begin
      $display("sliding_window_negative_rank_filter_test: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/swnr_pkg.sv
src/swnr_cell.sv
src/swnr_select.sv
src/sliding_window_negative_rank_filter.sv
dv/sliding_window_negative_rank_filter_test.sv
